@@ hw/rtl/gdrs_pkg.sv @@
// shared types and constants of the diamond range stamp block
package gdrs_pkg;

  // map storage geometry
  localparam int MAX_DIM    = 64;
  localparam int DIM_BITS   = 6;
  localparam int ADDR_BITS  = 2 * DIM_BITS;
  localparam int MAX_RADIUS = 15;

  // operation codes
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SET  = 3'd1;
  localparam logic [2:0] OP_RING = 3'd2;
  localparam logic [2:0] OP_READ = 3'd3;
  localparam logic [2:0] OP_FILL = 3'd4;

  // configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // signed coordinate wide enough for a center plus or minus a radius
  typedef logic signed [8:0] coord_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PASS,
    ST_ROW,
    ST_CELL,
    ST_RDREQ,
    ST_RDWAIT,
    ST_DONE
  } state_t;

endpackage

@@ hw/rtl/grid_diamond_range_stamp.sv @@
// diamond range stamp block: byte grid map with clipped diamond updates
//
// Input channel (in_valid / in_stall) takes one operation per transaction:
// add diamond, set diamond, ring increment, read cell or fill map. Each
// transaction yields exactly one result transaction on the output channel
// (out_valid / out_stall) carrying read_data and op_echo.
// Configuration writes (cfg_valid / cfg_ready, always ready) set map_width
// (index 0) and map_height (index 1); the user makes them while the block
// is idle, which the block itself does not enforce. One item is worked at
// a time; in_stall stays high until it is finished. Diamond operations do
// one read-modify-write per cell through the map RAM, one cell per cycle;
// a ring runs two passes. Fill sweeps all 4096 cells, one per cycle. After
// reset the block runs a clearing sweep of all 4096 map cells before it
// accepts any item; configuration writes are taken during it.
// A stalled result waits in the output register; the next item is accepted
// meanwhile and its result is held until the output register frees.
module grid_diamond_range_stamp (
  input  logic              clk,
  input  logic              rst,
  // input transactions
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        operation,
  input  logic [5:0]        x_pos,
  input  logic [5:0]        y_pos,
  input  logic [3:0]        range_min,
  input  logic [3:0]        range_max,
  input  logic signed [7:0] value,
  // result transactions
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        read_data,
  output logic [2:0]        op_echo,
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [6:0]        cfg_data
);

  localparam int ADDR_BITS = gdrs_pkg::ADDR_BITS;
  localparam int DIM_BITS  = gdrs_pkg::DIM_BITS;

  // map storage
  logic [7:0] mem [gdrs_pkg::MAX_DIM * gdrs_pkg::MAX_DIM];
  logic [7:0] mem_q;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [ADDR_BITS-1:0] mem_waddr;
  logic [7:0] mem_wdata;
  logic mem_we;

  // control registers
  gdrs_pkg::state_t state, state_next;
  logic [6:0] map_width, map_height;
  logic [ADDR_BITS-1:0] sweep_cnt, sweep_cnt_next;
  logic init_sweep, init_sweep_next;
  logic [7:0] fill_byte, fill_byte_next;
  logic wr_pending, wr_pending_next;
  logic out_valid_next;

  // item registers
  logic [2:0] op, op_next;
  logic [DIM_BITS-1:0] cx, cx_next, cy, cy_next;
  logic [3:0] rmin, rmin_next;
  logic [3:0] rmax, rmax_next;
  logic [7:0] val, val_next;
  logic second_pass, second_pass_next;
  logic signed [5:0] radius, radius_next;
  logic cell_add, cell_add_next;
  logic [7:0] cell_val, cell_val_next;
  gdrs_pkg::coord_t cur_y, cur_y_next, y_hi, y_hi_next;
  gdrs_pkg::coord_t cur_x, cur_x_next, x_hi, x_hi_next;
  logic [ADDR_BITS-1:0] wr_addr, wr_addr_next;
  logic [7:0] res_data, res_data_next;
  logic [7:0] read_data_next;
  logic [2:0] op_echo_next;

  // derived geometry
  gdrs_pkg::coord_t cx_s, cy_s, w_last, h_last, rad_s;
  gdrs_pkg::coord_t dy, dy_abs, span, x_lo, x_hi_row, y_lo;
  logic [6:0] w_clamp, h_clamp;

  // clamp the configured size to the storage grid
  always_comb begin
    w_clamp = (map_width > 7'(gdrs_pkg::MAX_DIM)) ? 7'(gdrs_pkg::MAX_DIM) : map_width;
    h_clamp = (map_height > 7'(gdrs_pkg::MAX_DIM)) ? 7'(gdrs_pkg::MAX_DIM) : map_height;
    w_last  = $signed({2'b00, w_clamp}) - 9'sd1;
    h_last  = $signed({2'b00, h_clamp}) - 9'sd1;
    cx_s    = $signed({3'b000, cx});
    cy_s    = $signed({3'b000, cy});
    rad_s   = gdrs_pkg::coord_t'(radius);
  end

  // row bounds of the current diamond row, clipped to the map
  always_comb begin
    dy       = cur_y - cy_s;
    dy_abs   = (dy < 0) ? -dy : dy;
    span     = rad_s - dy_abs;
    x_lo     = (cx_s - span < 0) ? 9'sd0 : cx_s - span;
    x_hi_row = (cx_s + span > w_last) ? w_last : cx_s + span;
    y_lo     = (cy_s - rad_s < 0) ? 9'sd0 : cy_s - rad_s;
  end

  assign in_stall  = (state != gdrs_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // sequencer: next state and datapath controls
  always_comb begin
    state_next       = state;
    sweep_cnt_next   = sweep_cnt;
    init_sweep_next  = init_sweep;
    fill_byte_next   = fill_byte;
    wr_pending_next  = 1'b0;
    op_next          = op;
    cx_next          = cx;
    cy_next          = cy;
    rmin_next        = rmin;
    rmax_next        = rmax;
    val_next         = val;
    second_pass_next = second_pass;
    radius_next      = radius;
    cell_add_next    = cell_add;
    cell_val_next    = cell_val;
    cur_y_next       = cur_y;
    y_hi_next        = y_hi;
    cur_x_next       = cur_x;
    x_hi_next        = x_hi;
    wr_addr_next     = wr_addr;
    res_data_next    = res_data;
    out_valid_next   = out_valid && out_stall;
    read_data_next   = read_data;
    op_echo_next     = op_echo;
    rd_addr          = {cy, cx};

    case (state)
      gdrs_pkg::ST_SWEEP: begin
        sweep_cnt_next = sweep_cnt + 1'b1;
        if (sweep_cnt == '1) begin
          init_sweep_next = 1'b0;
          state_next = init_sweep ? gdrs_pkg::ST_IDLE : gdrs_pkg::ST_DONE;
        end
      end
      gdrs_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_next          = operation;
          cx_next          = x_pos;
          cy_next          = y_pos;
          rmin_next        = range_min;
          rmax_next        = range_max;
          val_next         = $unsigned(value);
          res_data_next    = '0;
          second_pass_next = 1'b0;
          radius_next      = $signed({2'b00, range_max});
          case (operation)
            gdrs_pkg::OP_ADD: begin
              cell_add_next = 1'b1;
              cell_val_next = $unsigned(value);
              state_next    = gdrs_pkg::ST_PASS;
            end
            gdrs_pkg::OP_SET: begin
              cell_add_next = 1'b0;
              cell_val_next = $unsigned(value);
              state_next    = gdrs_pkg::ST_PASS;
            end
            gdrs_pkg::OP_RING: begin
              cell_add_next = 1'b1;
              cell_val_next = 8'd1;
              state_next    = gdrs_pkg::ST_PASS;
            end
            gdrs_pkg::OP_READ: state_next = gdrs_pkg::ST_RDREQ;
            gdrs_pkg::OP_FILL: begin
              fill_byte_next = $unsigned(value);
              sweep_cnt_next = '0;
              state_next     = gdrs_pkg::ST_SWEEP;
            end
            default: state_next = gdrs_pkg::ST_DONE;
          endcase
        end
      end
      // set up the row range of one pass; a negative radius yields no rows
      gdrs_pkg::ST_PASS: begin
        cur_y_next = y_lo;
        y_hi_next  = (cy_s + rad_s > h_last) ? h_last : cy_s + rad_s;
        state_next = gdrs_pkg::ST_ROW;
      end
      gdrs_pkg::ST_ROW: begin
        if (cur_y > y_hi) begin
          if (op == gdrs_pkg::OP_RING && !second_pass) begin
            // inner pass takes one back off below range_min
            second_pass_next = 1'b1;
            radius_next      = $signed({2'b00, rmin}) - 6'sd1;
            cell_val_next    = 8'hff;
            state_next       = gdrs_pkg::ST_PASS;
          end else begin
            state_next = gdrs_pkg::ST_DONE;
          end
        end else if (x_lo > x_hi_row) begin
          cur_y_next = cur_y + 9'sd1;
        end else begin
          cur_x_next = x_lo;
          x_hi_next  = x_hi_row;
          state_next = gdrs_pkg::ST_CELL;
        end
      end
      // read one cell per cycle, written back in the following cycle
      gdrs_pkg::ST_CELL: begin
        rd_addr         = {cur_y[DIM_BITS-1:0], cur_x[DIM_BITS-1:0]};
        wr_pending_next = 1'b1;
        wr_addr_next    = {cur_y[DIM_BITS-1:0], cur_x[DIM_BITS-1:0]};
        if (cur_x == x_hi) begin
          cur_y_next = cur_y + 9'sd1;
          state_next = gdrs_pkg::ST_ROW;
        end else begin
          cur_x_next = cur_x + 9'sd1;
        end
      end
      gdrs_pkg::ST_RDREQ: state_next = gdrs_pkg::ST_RDWAIT;
      gdrs_pkg::ST_RDWAIT: begin
        res_data_next = mem_q;
        state_next    = gdrs_pkg::ST_DONE;
      end
      gdrs_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          read_data_next = res_data;
          op_echo_next   = op;
          state_next     = gdrs_pkg::ST_IDLE;
        end
      end
      default: state_next = gdrs_pkg::ST_IDLE;
    endcase
  end

  // map write port: sweep or pending read-modify-write
  always_comb begin
    mem_we    = (state == gdrs_pkg::ST_SWEEP) || wr_pending;
    mem_waddr = wr_pending ? wr_addr : sweep_cnt;
    if (wr_pending) begin
      mem_wdata = cell_add ? mem_q + cell_val : cell_val;
    end else begin
      mem_wdata = fill_byte;
    end
  end

  // map memory
  always_ff @(posedge clk) begin
    mem_q <= mem[rd_addr];
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gdrs_pkg::ST_SWEEP;
      sweep_cnt  <= '0;
      init_sweep <= 1'b1;
      fill_byte  <= '0;
      wr_pending <= 1'b0;
      out_valid  <= 1'b0;
      map_width  <= 7'd64;
      map_height <= 7'd64;
    end else begin
      state      <= state_next;
      sweep_cnt  <= sweep_cnt_next;
      init_sweep <= init_sweep_next;
      fill_byte  <= fill_byte_next;
      wr_pending <= wr_pending_next;
      out_valid  <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gdrs_pkg::CFG_WIDTH:  map_width  <= cfg_data;
          gdrs_pkg::CFG_HEIGHT: map_height <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op          <= op_next;
    cx          <= cx_next;
    cy          <= cy_next;
    rmin        <= rmin_next;
    rmax        <= rmax_next;
    val         <= val_next;
    second_pass <= second_pass_next;
    radius      <= radius_next;
    cell_add    <= cell_add_next;
    cell_val    <= cell_val_next;
    cur_y       <= cur_y_next;
    y_hi        <= y_hi_next;
    cur_x       <= cur_x_next;
    x_hi        <= x_hi_next;
    wr_addr     <= wr_addr_next;
    res_data    <= res_data_next;
    read_data   <= read_data_next;
    op_echo     <= op_echo_next;
  end

`ifndef SYNTH
  // write-back only follows a cell read
  a_wr_after_cell: assert property (@(posedge clk) disable iff (rst)
    wr_pending |-> $past(state) == gdrs_pkg::ST_CELL)
    else $error("write-back without a cell read");

  // cells visited lie inside the clipped row
  a_cell_in_map: assert property (@(posedge clk) disable iff (rst)
    state == gdrs_pkg::ST_CELL |-> (cur_x >= 0 && cur_x <= x_hi && cur_x <= w_last
                                    && cur_y >= 0 && cur_y <= h_last))
    else $error("cell outside the map");

  // a new result only comes from the done state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid && out_stall)) |-> $past(state) == gdrs_pkg::ST_DONE)
    else $error("result without a finished item");

  // only a read returns map data
  a_read_data_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && op_echo != gdrs_pkg::OP_READ) |-> read_data == 8'd0)
    else $error("nonzero data for a non-read operation");

  // no pending first-pass value survives into the inner ring pass
  a_ring_pass_val: assert property (@(posedge clk) disable iff (rst)
    (state == gdrs_pkg::ST_CELL && second_pass) |-> cell_val == 8'hff)
    else $error("inner ring pass with wrong step");
`endif

endmodule
